[rtl/core/rgb_to_hsv_8bit_assert.svh]
// Assertion macros for the RGB to HSV converter.
// No dependencies; included by the modules that carry assertions.
`ifndef RGB_TO_HSV_8BIT_ASSERT_SVH
`define RGB_TO_HSV_8BIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define RHSV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rgb_to_hsv_8bit assertion failed");
`define RHSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_8bit assertion failed");
`else
`define RHSV_ASSERT(lbl, clk, rstn, prop)
`define RHSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/rhsv_pkg.sv]
// Shared widths and pipeline payload types for the RGB to HSV converter.
// No dependencies.
package rhsv_pkg;

  localparam int ChanW     = 8;
  localparam int PixelW    = 3 * ChanW;
  localparam int NumW      = 11;
  localparam int HueRemW   = NumW + ChanW;
  localparam int HueDivW   = NumW;
  localparam int SatRemW   = 2 * ChanW;
  localparam int QuoW      = ChanW;
  localparam int StepBits  = 2;
  localparam int DivStages = QuoW / StepBits;

  typedef struct packed {
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] delta;
    logic [NumW-1:0]  num;
  } prep_t;

  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [QuoW-1:0]    hue_quo;
    logic [SatRemW-1:0] sat_rem;
    logic [ChanW-1:0]   sat_div;
    logic [QuoW-1:0]    sat_quo;
    logic [ChanW-1:0]   value;
  } div_t;

endpackage

[rtl/core/rhsv_prep.sv]
// Front stage: channel max/min, spread and hue sector numerator.
// Depends on rhsv_pkg.
module rhsv_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rhsv_pkg::PixelW-1:0]   pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rhsv_pkg::prep_t               out_data_o
);

  logic [rhsv_pkg::ChanW-1:0] red, green, blue, hi, lo;
  logic [rhsv_pkg::NumW-1:0]  r_w, g_w, b_w, d_w;
  rhsv_pkg::prep_t            data_d, data_q;
  logic                       valid_q;

  assign red   = pixel_i[3*rhsv_pkg::ChanW-1:2*rhsv_pkg::ChanW];
  assign green = pixel_i[2*rhsv_pkg::ChanW-1:rhsv_pkg::ChanW];
  assign blue  = pixel_i[rhsv_pkg::ChanW-1:0];

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
  end

  assign r_w = {{(rhsv_pkg::NumW-rhsv_pkg::ChanW){1'b0}}, red};
  assign g_w = {{(rhsv_pkg::NumW-rhsv_pkg::ChanW){1'b0}}, green};
  assign b_w = {{(rhsv_pkg::NumW-rhsv_pkg::ChanW){1'b0}}, blue};
  assign d_w = {{(rhsv_pkg::NumW-rhsv_pkg::ChanW){1'b0}}, hi - lo};

  always_comb begin
    data_d.value = hi;
    data_d.delta = hi - lo;
    if (red == hi) begin
      if (green < blue) begin
        data_d.num = (d_w << 2) + (d_w << 1) - (b_w - g_w);
      end else begin
        data_d.num = g_w - b_w;
      end
    end else if (green == hi) begin
      data_d.num = (d_w << 1) + b_w - r_w;
    end else begin
      data_d.num = (d_w << 2) + r_w - g_w;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/rhsv_scale.sv]
// Scaling stage: builds dividends and divisors for hue and saturation.
// Depends on rhsv_pkg.
module rhsv_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rhsv_pkg::prep_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rhsv_pkg::div_t  out_data_o
);

  logic [rhsv_pkg::HueRemW-1:0] num_w;
  logic [rhsv_pkg::SatRemW-1:0] delta_w;
  logic [rhsv_pkg::HueDivW-1:0] delta_n;
  rhsv_pkg::div_t               data_d, data_q;
  logic                         valid_q;

  assign num_w   = {{(rhsv_pkg::HueRemW-rhsv_pkg::NumW){1'b0}}, in_data_i.num};
  assign delta_w = {{(rhsv_pkg::SatRemW-rhsv_pkg::ChanW){1'b0}}, in_data_i.delta};
  assign delta_n = {{(rhsv_pkg::HueDivW-rhsv_pkg::ChanW){1'b0}}, in_data_i.delta};

  always_comb begin
    data_d.hue_rem = (num_w << rhsv_pkg::ChanW) - num_w;
    data_d.sat_rem = (delta_w << rhsv_pkg::ChanW) - delta_w;
    data_d.hue_quo = '0;
    data_d.sat_quo = '0;
    data_d.value   = in_data_i.value;
    // zero spread: dividends are zero, so any nonzero divisor yields zero
    if (in_data_i.delta == '0) begin
      data_d.hue_div = '1;
      data_d.sat_div = '1;
    end else begin
      data_d.hue_div = (delta_n << 2) + (delta_n << 1);
      data_d.sat_div = in_data_i.value;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/rhsv_div_step.sv]
// Divider stage: resolves StepBits quotient bits of both divisions.
// Depends on rhsv_pkg.
module rhsv_div_step #(
  parameter int StageIdx = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rhsv_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rhsv_pkg::div_t out_data_o
);

  rhsv_pkg::div_t               data_d, data_q;
  logic                         valid_q;
  logic [rhsv_pkg::HueRemW-1:0] hue_sh;
  logic [rhsv_pkg::SatRemW-1:0] sat_sh;

  always_comb begin
    data_d = in_data_i;
    hue_sh = '0;
    sat_sh = '0;
    for (int j = 0; j < rhsv_pkg::StepBits; j++) begin
      hue_sh = {{(rhsv_pkg::HueRemW-rhsv_pkg::HueDivW){1'b0}}, data_d.hue_div}
               << (rhsv_pkg::QuoW - 1 - StageIdx * rhsv_pkg::StepBits - j);
      sat_sh = {{(rhsv_pkg::SatRemW-rhsv_pkg::ChanW){1'b0}}, data_d.sat_div}
               << (rhsv_pkg::QuoW - 1 - StageIdx * rhsv_pkg::StepBits - j);
      if (data_d.hue_rem >= hue_sh) begin
        data_d.hue_rem = data_d.hue_rem - hue_sh;
        data_d.hue_quo[3'(rhsv_pkg::QuoW - 1 - StageIdx * rhsv_pkg::StepBits - j)] = 1'b1;
      end
      if (data_d.sat_rem >= sat_sh) begin
        data_d.sat_rem = data_d.sat_rem - sat_sh;
        data_d.sat_quo[3'(rhsv_pkg::QuoW - 1 - StageIdx * rhsv_pkg::StepBits - j)] = 1'b1;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/rgb_to_hsv_8bit.sv]
// RGB to HSV converter, top level: prep stage, scale stage, four divider stages.
// Each stage registers its request; throughput 1 pixel per cycle while m_axis_tready is high.
// Each stage holds one request and accepts a new one whenever it empties, so bubbles close up.
// The restoring divider resolves 2 quotient bits per stage over 8 bits.
// Reset: asynchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on rhsv_pkg, rhsv_prep, rhsv_scale, rhsv_div_step, rgb_to_hsv_8bit_assert.svh.
`include "rgb_to_hsv_8bit_assert.svh"

module rgb_to_hsv_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // color_rgb[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // hue[7:0], saturation[15:8], brightness[23:16]
);

  rhsv_pkg::prep_t                prep_data;
  logic                           prep_valid, prep_ready;
  rhsv_pkg::div_t                 div_data [rhsv_pkg::DivStages+1];
  logic [rhsv_pkg::DivStages:0]   div_valid, div_ready;
  rhsv_pkg::div_t                 res;

  rhsv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_i     (s_axis_tdata),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  rhsv_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_data_i   (prep_data),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_data[0])
  );

  for (genvar i = 0; i < rhsv_pkg::DivStages; i++) begin : g_div
    rhsv_div_step #(
      .StageIdx (i)
    ) u_div_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[i]),
      .in_ready_o  (div_ready[i]),
      .in_data_i   (div_data[i]),
      .out_valid_o (div_valid[i+1]),
      .out_ready_i (div_ready[i+1]),
      .out_data_o  (div_data[i+1])
    );
  end

  assign res                           = div_data[rhsv_pkg::DivStages];
  assign div_ready[rhsv_pkg::DivStages] = m_axis_tready;
  assign m_axis_tvalid                 = div_valid[rhsv_pkg::DivStages];
  assign m_axis_tdata                  = {res.value, res.sat_quo, res.hue_quo};

  `RHSV_ASSERT(a_gray_hue_zero, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tdata[15:8] == 8'd0) |-> (m_axis_tdata[7:0] == 8'd0))
  `RHSV_ASSERT(a_hue_below_full, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'hFF))
  `RHSV_ASSERT(a_black_sat_zero, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tdata[23:16] == 8'd0) |-> (m_axis_tdata[15:8] == 8'd0))
  `RHSV_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
  `RHSV_ASSERT_NEXT(a_full_pipe_drains, clk_i, rst_ni,
    (!s_axis_tready && m_axis_tready), s_axis_tready)

endmodule
